[hw/rtl/dur_pkg.sv]
// ============================================================================
// dur_pkg
// Shared types and constants for the duration string parser.
// ============================================================================
package dur_pkg;

  // largest value a duration may take
  localparam logic [62:0] LIM = '1;

  localparam int FRAC_DIGITS_DEF = 9;
  // fraction is held as twelve decimal places, split into four groups of three
  localparam int FRAC_SLOTS  = 12;
  localparam int FRAC_GROUPS = 4;

  // characters
  localparam logic [7:0] CH_0   = 8'h30;
  localparam logic [7:0] CH_9   = 8'h39;
  localparam logic [7:0] CH_DOT = 8'h2e;
  localparam logic [7:0] CH_A   = 8'h61;
  localparam logic [7:0] CH_Z   = 8'h7a;

  // unit codes
  localparam logic [2:0] UNIT_MS  = 3'd0;
  localparam logic [2:0] UNIT_SEC = 3'd1;
  localparam logic [2:0] UNIT_MIN = 3'd2;
  localparam logic [2:0] UNIT_HR  = 3'd3;
  localparam logic [2:0] UNIT_DAY = 3'd4;

  // status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_START  = 3'd1;
  localparam logic [2:0] ST_UNEXPECTED = 3'd2;
  localparam logic [2:0] ST_NO_UNIT    = 3'd3;
  localparam logic [2:0] ST_BAD_NUMBER = 3'd4;
  localparam logic [2:0] ST_BAD_UNIT   = 3'd5;
  localparam logic [2:0] ST_OVERFLOW   = 3'd6;

  typedef struct packed {
    logic [7:0] char_in;
    logic       last_char;
  } char_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [62:0] duration_ns;
  } result_word_t;

  typedef struct packed {
    logic start;
    logic unexp;
    logic no_unit;
    logic bad_num;
    logic bad_unit;
  } err_t;

  // one number/unit pair handed from the front end to the term pipeline
  typedef struct packed {
    logic                             last;
    logic                             term;
    err_t                             err;
    logic [62:0]                      int_acc;
    logic [2:0]                       unit;
    logic [FRAC_GROUPS-1:0][9:0]      grp;
  } job_t;

  // finished term in nanoseconds
  typedef struct packed {
    logic        last;
    logic        term;
    err_t        err;
    logic        ovf;
    logic [62:0] t;
  } term_t;

endpackage

[hw/rtl/dur_front.sv]
// ============================================================================
// dur_front
// Per-byte scanner: number and unit accumulators, error flags, pair jobs.
// ============================================================================
module dur_front #(
  parameter int FRAC_DIGITS = dur_pkg::FRAC_DIGITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                char_valid,
  input  dur_pkg::char_word_t char_word,
  output logic                job_vld,
  output dur_pkg::job_t       job
);
  import dur_pkg::*;

  localparam int CNT_W = $clog2(FRAC_DIGITS + 1);

  typedef struct packed {
    logic       known;
    logic [2:0] code;
  } unit_dec_t;

  function automatic unit_dec_t unit_decode(input logic [23:0] ch, input logic [2:0] len);
    unit_dec_t r;
    r.known = 1'b1;
    r.code  = UNIT_MS;
    if (len == 3'd1 && ch == 24'h000073) r.code = UNIT_SEC;
    else if (len == 3'd1 && ch == 24'h00006d) r.code = UNIT_MIN;
    else if (len == 3'd1 && ch == 24'h000068) r.code = UNIT_HR;
    else if (len == 3'd1 && ch == 24'h000064) r.code = UNIT_DAY;
    else if (len == 3'd2 && ch == 24'h006d73) r.code = UNIT_MS;
    else if (len == 3'd2 && ch == 24'h006872) r.code = UNIT_HR;
    else if (len == 3'd3 && ch == 24'h736563) r.code = UNIT_SEC;
    else if (len == 3'd3 && ch == 24'h6d696e) r.code = UNIT_MIN;
    else if (len == 3'd3 && ch == 24'h646179) r.code = UNIT_DAY;
    else r.known = 1'b0;
    return r;
  endfunction

  localparam logic [62:0] INT_SAT = (LIM - 63'd9) / 63'd10;

  // state
  logic              in_unit, in_unit_next;
  logic              at_start, at_start_next;
  logic [62:0]       int_acc, int_acc_next;
  logic [3:0]        frac_dig [FRAC_DIGITS];
  logic [3:0]        frac_dig_next [FRAC_DIGITS];
  logic [CNT_W-1:0]  frac_cnt, frac_cnt_next;
  logic              dot_seen, dot_seen_next;
  logic [23:0]       unit_chars, unit_chars_next;
  logic [2:0]        unit_len, unit_len_next;
  err_t              err, err_next;

  logic [7:0]        c;
  logic [3:0]        dval;
  logic              is_digit, is_dot, is_num, is_lower, halted, halted_next;
  logic              do_feed, do_close, fin_close, close_any, no_unit;
  logic [62:0]       base_int;
  logic              base_dot;
  logic [CNT_W-1:0]  base_cnt;
  unit_dec_t         dec;
  logic              accept, restart;
  logic [3:0]        pad [FRAC_SLOTS];
  job_t              job_next;

  assign accept  = char_valid & en;
  assign restart = rst | (accept & char_word.last_char);

  for (genvar s = 0; s < FRAC_SLOTS; s++) begin : g_pad
    if (s < FRAC_DIGITS) begin : g_used
      assign pad[s] = frac_dig[s];
    end else begin : g_zero
      assign pad[s] = '0;
    end
  end

  always_comb begin
    c        = char_word.char_in;
    dval     = c[3:0];
    is_digit = (c >= CH_0) && (c <= CH_9);
    is_dot   = (c == CH_DOT);
    is_num   = is_digit | is_dot;
    is_lower = (c >= CH_A) && (c <= CH_Z);
    halted   = err.start | err.unexp;

    in_unit_next    = in_unit;
    at_start_next   = at_start;
    unit_chars_next = unit_chars;
    unit_len_next   = unit_len;
    err_next        = err;
    do_feed         = 1'b0;
    do_close        = 1'b0;

    if (!halted) begin
      if (at_start) begin
        at_start_next = 1'b0;
        if (!is_digit) err_next.start = 1'b1;
        else do_feed = 1'b1;
      end else if (!in_unit) begin
        if (is_num) begin
          do_feed = 1'b1;
        end else if (is_lower) begin
          in_unit_next    = 1'b1;
          unit_chars_next = {16'h0000, c};
          unit_len_next   = 3'd1;
        end else begin
          err_next.unexp = 1'b1;
        end
      end else begin
        if (is_num) begin
          // a number after a unit closes the pair; only the last number may be fractional
          do_close     = 1'b1;
          do_feed      = 1'b1;
          in_unit_next = 1'b0;
          if (dot_seen) err_next.bad_num = 1'b1;
        end else if (is_lower) begin
          if (unit_len >= 3'd3) begin
            unit_len_next = 3'd4;
          end else begin
            unit_chars_next = {unit_chars[15:0], c};
            unit_len_next   = unit_len + 3'd1;
          end
        end else begin
          err_next.unexp = 1'b1;
        end
      end
    end

    // number feed, starting from a cleared number when a pair was just closed
    base_int = do_close ? '0 : int_acc;
    base_dot = do_close ? 1'b0 : dot_seen;
    base_cnt = do_close ? '0 : frac_cnt;
    for (int s = 0; s < FRAC_DIGITS; s++) begin
      frac_dig_next[s] = do_close ? 4'd0 : frac_dig[s];
    end
    int_acc_next  = base_int;
    dot_seen_next = base_dot;
    frac_cnt_next = base_cnt;
    if (do_feed) begin
      if (is_dot) begin
        if (base_dot) err_next.bad_num = 1'b1;
        dot_seen_next = 1'b1;
      end else if (!base_dot) begin
        if (base_int > INT_SAT) int_acc_next = LIM;
        else int_acc_next = (base_int << 3) + (base_int << 1) + 63'(dval);
      end else if (base_cnt < CNT_W'(FRAC_DIGITS)) begin
        for (int s = 0; s < FRAC_DIGITS; s++) begin
          if (base_cnt == CNT_W'(s)) frac_dig_next[s] = dval;
        end
        frac_cnt_next = base_cnt + CNT_W'(1);
      end
    end

    halted_next = err_next.start | err_next.unexp;
    fin_close   = char_word.last_char & ~halted_next & in_unit_next;
    no_unit     = char_word.last_char & ~halted_next & ~in_unit_next;
    close_any   = do_close | fin_close;

    dec = do_close ? unit_decode(unit_chars, unit_len)
                   : unit_decode(unit_chars_next, unit_len_next);
    if (close_any && !dec.known) err_next.bad_unit = 1'b1;

    job_next         = '0;
    job_next.last    = char_word.last_char;
    job_next.term    = close_any & dec.known;
    job_next.err     = err_next;
    job_next.err.no_unit = no_unit;
    job_next.int_acc = int_acc;
    job_next.unit    = dec.code;
    for (int g = 0; g < FRAC_GROUPS; g++) begin
      job_next.grp[g] = 10'(pad[3*g]) * 10'd100 + 10'(pad[3*g+1]) * 10'd10
                      + 10'(pad[3*g+2]);
    end
  end

  always_ff @(posedge clk) begin
    if (restart) begin
      in_unit    <= 1'b0;
      at_start   <= 1'b1;
      int_acc    <= '0;
      frac_cnt   <= '0;
      dot_seen   <= 1'b0;
      unit_chars <= '0;
      unit_len   <= '0;
      err        <= '0;
      for (int s = 0; s < FRAC_DIGITS; s++) frac_dig[s] <= '0;
    end else if (accept) begin
      in_unit    <= in_unit_next;
      at_start   <= at_start_next;
      int_acc    <= int_acc_next;
      frac_cnt   <= frac_cnt_next;
      dot_seen   <= dot_seen_next;
      unit_chars <= unit_chars_next;
      unit_len   <= unit_len_next;
      err        <= err_next;
      for (int s = 0; s < FRAC_DIGITS; s++) frac_dig[s] <= frac_dig_next[s];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_vld <= 1'b0;
    end else if (en) begin
      job_vld <= accept & (close_any | char_word.last_char);
    end
  end

  always_ff @(posedge clk) begin
    if (en) job <= job_next;
  end

endmodule

[hw/rtl/dur_term.sv]
// ============================================================================
// dur_term
// Four-stage pipeline that turns one number/unit pair into nanoseconds.
// ============================================================================
module dur_term (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           job_vld,
  input  dur_pkg::job_t  job,
  output logic           term_vld,
  output dur_pkg::term_t term
);
  import dur_pkg::*;

  // floor(y / 125) = (y * RECIP_125) >> 31 for y below 2^24
  localparam logic [24:0] RECIP_125 = 25'((64'd1 << 31) / 64'd125 + 64'd1);

  localparam logic [46:0] UNS_MS  = 47'd1_000_000;
  localparam logic [46:0] UNS_SEC = 47'd1_000_000_000;
  localparam logic [46:0] UNS_MIN = 47'd60_000_000_000;
  localparam logic [46:0] UNS_HR  = 47'd3_600_000_000_000;
  localparam logic [46:0] UNS_DAY = 47'd86_400_000_000_000;

  function automatic logic [46:0] unit_ns(input logic [2:0] code);
    logic [46:0] r;
    unique case (code)
      UNIT_MS:  r = UNS_MS;
      UNIT_SEC: r = UNS_SEC;
      UNIT_MIN: r = UNS_MIN;
      UNIT_HR:  r = UNS_HR;
      UNIT_DAY: r = UNS_DAY;
      default:  r = '0;
    endcase
    return r;
  endfunction

  // largest integer part whose term still fits
  function automatic logic [62:0] int_lim(input logic [2:0] code);
    logic [62:0] r;
    unique case (code)
      UNIT_MS:  r = LIM / 63'(UNS_MS);
      UNIT_SEC: r = LIM / 63'(UNS_SEC);
      UNIT_MIN: r = LIM / 63'(UNS_MIN);
      UNIT_HR:  r = LIM / 63'(UNS_HR);
      UNIT_DAY: r = LIM / 63'(UNS_DAY);
      default:  r = '0;
    endcase
    return r;
  endfunction

  // unit in microseconds, in milliseconds, and in seconds (zero for ms)
  function automatic logic [36:0] unit_us(input logic [2:0] code);
    logic [36:0] r;
    unique case (code)
      UNIT_MS:  r = 37'd1_000;
      UNIT_SEC: r = 37'd1_000_000;
      UNIT_MIN: r = 37'd60_000_000;
      UNIT_HR:  r = 37'd3_600_000_000;
      UNIT_DAY: r = 37'd86_400_000_000;
      default:  r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [26:0] unit_msec(input logic [2:0] code);
    logic [26:0] r;
    unique case (code)
      UNIT_MS:  r = 27'd1;
      UNIT_SEC: r = 27'd1_000;
      UNIT_MIN: r = 27'd60_000;
      UNIT_HR:  r = 27'd3_600_000;
      UNIT_DAY: r = 27'd86_400_000;
      default:  r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [16:0] unit_sec(input logic [2:0] code);
    logic [16:0] r;
    unique case (code)
      UNIT_MS:  r = 17'd0;
      UNIT_SEC: r = 17'd1;
      UNIT_MIN: r = 17'd60;
      UNIT_HR:  r = 17'd3_600;
      UNIT_DAY: r = 17'd86_400;
      default:  r = '0;
    endcase
    return r;
  endfunction

  typedef struct packed {
    logic        last;
    logic        term;
    err_t        err;
    logic        iovf;
    logic [45:0] p0;
    logic [44:0] p1;
    logic [45:0] p2;
    logic [44:0] p3;
    logic [46:0] q1;
    logic [36:0] q2;
    logic [26:0] q3;
    logic [26:0] q4;
  } s1_t;

  typedef struct packed {
    logic        last;
    logic        term;
    err_t        err;
    logic        iovf;
    logic [63:0] tint;
    logic [47:0] fsum;
    logic [48:0] yq;
  } s2_t;

  typedef struct packed {
    logic        last;
    logic        term;
    err_t        err;
    logic        iovf;
    logic [63:0] tint;
    logic [47:0] f;
  } s3_t;

  logic  s1_vld, s2_vld, s3_vld;
  s1_t   s1, s1_next;
  s2_t   s2, s2_next;
  s3_t   s3, s3_next;
  term_t term_next;

  logic [46:0] uns;
  logic [21:0] il, ih;
  logic [23:0] ul;
  logic [22:0] uh;
  logic [63:0] tsum;

  // stage 1: integer partial products, fraction group products, range check
  always_comb begin
    uns = unit_ns(job.unit);
    il  = job.int_acc[21:0];
    ih  = job.int_acc[43:22];
    ul  = uns[23:0];
    uh  = uns[46:24];
    s1_next.last = job.last;
    s1_next.term = job.term;
    s1_next.err  = job.err;
    s1_next.iovf = job.int_acc > int_lim(job.unit);
    s1_next.p0   = 46'(il) * 46'(ul);
    s1_next.p1   = 45'(il) * 45'(uh);
    s1_next.p2   = 46'(ih) * 46'(ul);
    s1_next.p3   = 45'(ih) * 45'(uh);
    s1_next.q1   = 47'(job.grp[0]) * 47'(unit_us(job.unit));
    s1_next.q2   = 37'(job.grp[1]) * 37'(unit_msec(job.unit));
    s1_next.q3   = 27'(job.grp[2]) * 27'(unit_sec(job.unit));
    s1_next.q4   = 27'(job.grp[3]) * 27'(unit_sec(job.unit));
  end

  // stage 2: combine partial products, sum three fraction groups, scale last group down by 1000
  always_comb begin
    s2_next.last = s1.last;
    s2_next.term = s1.term;
    s2_next.err  = s1.err;
    s2_next.iovf = s1.iovf;
    s2_next.tint = 64'(s1.p0) + (64'(s1.p1) << 24) + (64'(s1.p2) << 22)
                 + (64'(s1.p3) << 46);
    s2_next.fsum = 48'(s1.q1) + 48'(s1.q2) + 48'(s1.q3);
    s2_next.yq   = 49'(s1.q4[26:3]) * 49'(RECIP_125);
  end

  // stage 3: fractional part of the term
  always_comb begin
    s3_next.last = s2.last;
    s3_next.term = s2.term;
    s3_next.err  = s2.err;
    s3_next.iovf = s2.iovf;
    s3_next.tint = s2.tint;
    s3_next.f    = s2.fsum + 48'(s2.yq[48:31]);
  end

  // stage 4: whole term
  always_comb begin
    tsum           = s3.tint + 64'(s3.f);
    term_next.last = s3.last;
    term_next.term = s3.term;
    term_next.err  = s3.err;
    term_next.ovf  = s3.iovf | tsum[63];
    term_next.t    = tsum[62:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld   <= 1'b0;
      s2_vld   <= 1'b0;
      s3_vld   <= 1'b0;
      term_vld <= 1'b0;
    end else if (en) begin
      s1_vld   <= job_vld;
      s2_vld   <= s1_vld;
      s3_vld   <= s2_vld;
      term_vld <= s3_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1   <= s1_next;
      s2   <= s2_next;
      s3   <= s3_next;
      term <= term_next;
    end
  end

endmodule

[hw/rtl/dur_accum.sv]
// ============================================================================
// dur_accum
// Running total per string, status priority and the result register.
// ============================================================================
module dur_accum (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  term_vld,
  input  dur_pkg::term_t        term,
  output logic                  hold,
  output logic                  result_valid,
  input  logic                  result_ready,
  output dur_pkg::result_word_t result_word
);
  import dur_pkg::*;

  logic [62:0] total;
  logic        ovf_acc;
  logic [63:0] sum;
  logic        ovf_all;
  logic [2:0]  status;
  logic        en;

  // only a finished string waiting on a full result register stops the pipe
  assign hold = result_valid & ~result_ready & term_vld & term.last;
  assign en   = ~hold;

  always_comb begin
    sum     = 64'(total) + 64'(term.t);
    ovf_all = ovf_acc | (term.term & (term.ovf | sum[63]));
    if (term.err.start)         status = ST_BAD_START;
    else if (term.err.unexp)    status = ST_UNEXPECTED;
    else if (term.err.no_unit)  status = ST_NO_UNIT;
    else if (term.err.bad_num)  status = ST_BAD_NUMBER;
    else if (term.err.bad_unit) status = ST_BAD_UNIT;
    else if (ovf_all)           status = ST_OVERFLOW;
    else                        status = ST_OK;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total        <= '0;
      ovf_acc      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && result_ready) result_valid <= 1'b0;
      if (en && term_vld) begin
        if (term.last) begin
          total        <= '0;
          ovf_acc      <= 1'b0;
          result_valid <= 1'b1;
        end else begin
          if (term.term) total <= sum[62:0];
          ovf_acc <= ovf_all;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && term_vld && term.last) begin
      result_word.status      <= status;
      result_word.duration_ns <= (status == ST_OK) ? sum[62:0] : '0;
    end
  end

endmodule

[hw/rtl/duration_string_parser_core.sv]
// ============================================================================
// duration_string_parser_core
// Parses a duration text one byte per word and returns status and nanoseconds.
// ============================================================================
// The final byte of a string passes the front register, four term stages and
// the result register before the result is valid.
// Throughput: one byte per cycle; input stalls only while the result register
// is still full and the next finished string has reached the result stage.
// Reset: synchronous rst clears the scanner state, the running total and all valids.
module duration_string_parser_core #(
  parameter int FRAC_DIGITS = dur_pkg::FRAC_DIGITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  char_valid,
  output logic                  char_ready,
  input  dur_pkg::char_word_t   char_word,
  output logic                  result_valid,
  input  logic                  result_ready,
  output dur_pkg::result_word_t result_word
);
  import dur_pkg::*;

  logic  adv, hold;
  logic  job_vld, term_vld;
  job_t  job;
  term_t term;

  assign adv        = ~hold;
  assign char_ready = adv;

  dur_front #(
    .FRAC_DIGITS (FRAC_DIGITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .en         (adv),
    .char_valid (char_valid),
    .char_word  (char_word),
    .job_vld    (job_vld),
    .job        (job)
  );

  dur_term u_term (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .job_vld  (job_vld),
    .job      (job),
    .term_vld (term_vld),
    .term     (term)
  );

  dur_accum u_accum (
    .clk          (clk),
    .rst          (rst),
    .term_vld     (term_vld),
    .term         (term),
    .hold         (hold),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_word  (result_word)
  );

endmodule
